### hw/rtl/hafn_pkg.sv
// shared types, register indexes and constants for the hid axis field normalizer
package hafn_pkg;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned QUEUE_DEPTH = 2;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] REG_AXIS_PRESENT      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_AXIS_BIT_POSITION = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_AXIS_BITS         = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SHIFT_AMOUNT      = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_AXIS_SIGNED       = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_DEVICE_INVERT     = 8'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_USER_INVERT       = 8'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_EXPECTED_ID       = 8'd7;

   // supported field widths
   localparam logic [4:0] BITS_8  = 5'd8;
   localparam logic [4:0] BITS_10 = 5'd10;
   localparam logic [4:0] BITS_12 = 5'd12;
   localparam logic [4:0] BITS_16 = 5'd16;

   localparam logic [15:0] CENTRE_16    = 16'h8000;
   localparam logic [7:0]  HALF_8       = 8'h80;
   localparam logic [15:0] LOW_LIMIT    = 16'h6000;
   localparam logic [15:0] HIGH_LIMIT   = 16'ha000;
   localparam logic [4:0]  WORD_BITS    = 5'd16;

   typedef struct packed {
      logic        axis_present;
      logic [10:0] axis_bit_position;
      logic [4:0]  axis_bits;
      logic [3:0]  shift_amount;
      logic        axis_signed;
      logic        device_invert;
      logic        user_invert;
      logic [7:0]  expected_id;
   } cfg_type;

   // one finished report as handed from front to back
   typedef struct packed {
      logic [7:0] field_low_byte;
      logic [7:0] field_high_byte;
      logic       id_ok;
   } job_type;

endpackage

### hw/rtl/hid_axis_field_normalizer_top.sv
// top level of the hid axis field normalizer: csr registers, front, queue and back
// throughput: one report byte per cycle while req_ready is high; a result word per report every cycle at best
// stages: two register stages between the accepted last byte and the result word
// (queue entry, then the result register)
// req_ready drops only while the two-entry report queue is full
// reset: synchronous, clears counters, queue and result valid; id_ok set, held value zero
module hid_axis_field_normalizer_top #(
   parameter int unsigned MAX_REPORT_BYTES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // report byte channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_report_byte,
   input  logic                              req_last_byte,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [15:0]                       rsp_axis_value,
   output logic                              rsp_below_low,
   output logic                              rsp_above_high,
   output logic                              rsp_report_matched,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hafn_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hafn_pkg::CSR_DATA_W-1:0]   csr_data
);
   import hafn_pkg::*;

   cfg_type cfg_ff;
   logic    byte_accept;
   logic    job_push, job_pop, q_full, q_valid;
   job_type push_job, head_job;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         // all registers zero except the field width, which starts at 8 bits
         cfg_ff <= '{axis_bits: BITS_8, default: '0};
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_AXIS_PRESENT:      cfg_ff.axis_present      <= csr_data[0];
            REG_AXIS_BIT_POSITION: cfg_ff.axis_bit_position <= csr_data[10:0];
            REG_AXIS_BITS:         cfg_ff.axis_bits         <= csr_data[4:0];
            REG_SHIFT_AMOUNT:      cfg_ff.shift_amount      <= csr_data[3:0];
            REG_AXIS_SIGNED:       cfg_ff.axis_signed       <= csr_data[0];
            REG_DEVICE_INVERT:     cfg_ff.device_invert     <= csr_data[0];
            REG_USER_INVERT:       cfg_ff.user_invert       <= csr_data[0];
            REG_EXPECTED_ID:       cfg_ff.expected_id       <= csr_data[7:0];
            default:               cfg_ff                   <= cfg_ff;
         endcase
      end
   end

   // bytes stall only when no queue slot is free for a finished report
   assign req_ready   = !q_full;
   assign byte_accept = req_valid && req_ready;

   hafn_front #(
      .MAX_REPORT_BYTES(MAX_REPORT_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .byte_accept (byte_accept),
      .report_byte (req_report_byte),
      .last_byte   (req_last_byte),
      .job_push    (job_push),
      .job         (push_job)
   );

   hafn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .pop       (job_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head_job  (head_job)
   );

   // held value lives in the back end, updated in report order
   hafn_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .job_valid          (q_valid),
      .job                (head_job),
      .job_pop            (job_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_axis_value     (rsp_axis_value),
      .rsp_below_low      (rsp_below_low),
      .rsp_above_high     (rsp_above_high),
      .rsp_report_matched (rsp_report_matched)
   );

endmodule

### hw/rtl/hafn_front.sv
// front end: byte counting, report id check and field byte capture
module hafn_front #(
   parameter int unsigned MAX_REPORT_BYTES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  hafn_pkg::cfg_type cfg,
   input  logic             byte_accept,
   input  logic [7:0]       report_byte,
   input  logic             last_byte,
   output logic             job_push,
   output hafn_pkg::job_type job
);
   import hafn_pkg::*;

   localparam int unsigned CW   = $clog2(MAX_REPORT_BYTES + 1);
   localparam int unsigned CMPW = 12;

   logic [CW-1:0]   count_ff, count_in;
   logic [7:0]      low_ff, low_in;
   logic [7:0]      high_ff, high_in;
   logic            id_ok_ff, id_ok_in;
   logic            first;
   logic            has_id;
   logic [CW-1:0]   pos;
   logic [CMPW-1:0] pos_x, base_x;

   assign first  = (count_ff == '0);
   assign has_id = (cfg.expected_id != 8'h00);
   assign pos    = has_id ? count_ff - CW'(1) : count_ff;
   assign pos_x  = {{(CMPW-CW){1'b0}}, pos};
   assign base_x = {4'b0000, cfg.axis_bit_position[10:3]};

   always_comb begin
      low_in   = first ? 8'h00 : low_ff;
      high_in  = first ? 8'h00 : high_ff;
      id_ok_in = first ? 1'b1 : id_ok_ff;
      count_in = count_ff;
      if (count_ff < CW'(MAX_REPORT_BYTES)) begin
         if (has_id && first) begin
            id_ok_in = (report_byte == cfg.expected_id);
         end else begin
            if (pos_x == base_x) low_in = report_byte;
            if (pos_x == base_x + CMPW'(1)) high_in = report_byte;
         end
         count_in = count_ff + CW'(1);
      end
      if (last_byte) count_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         id_ok_ff <= 1'b1;
         low_ff   <= 8'h00;
         high_ff  <= 8'h00;
      end else if (byte_accept) begin
         count_ff <= count_in;
         id_ok_ff <= id_ok_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
      end
   end

   assign job_push            = byte_accept && last_byte;
   assign job.field_low_byte  = low_in;
   assign job.field_high_byte = high_in;
   assign job.id_ok           = id_ok_in;

endmodule

### hw/rtl/hafn_queue.sv
// short flop queue of finished reports between front and back
module hafn_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hafn_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output hafn_pkg::job_type head_job
);
   import hafn_pkg::*;

   localparam int unsigned PW = $clog2(QUEUE_DEPTH);

   job_type      entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]   fill_ff;

   assign full      = (fill_ff == (PW+1)'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head_job  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + (PW+1)'(1);
            2'b01:   fill_ff <= fill_ff - (PW+1)'(1);
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

### hw/rtl/hafn_back.sv
// back end: normalization, held value and the result register
module hafn_back (
   input  logic              clock,
   input  logic              reset,
   input  hafn_pkg::cfg_type  cfg,
   input  logic              job_valid,
   input  hafn_pkg::job_type  job,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [15:0]       rsp_axis_value,
   output logic              rsp_below_low,
   output logic              rsp_above_high,
   output logic              rsp_report_matched
);
   import hafn_pkg::*;

   logic [15:0] held_ff, held_in;
   logic        valid_ff;
   logic [15:0] value_ff;
   logic        below_ff, above_ff, matched_ff;
   logic [15:0] word, v16, norm;
   logic [7:0]  v8;
   logic        inv;

   assign word = {job.field_high_byte, job.field_low_byte};
   assign inv  = cfg.device_invert ^ cfg.user_invert;

   always_comb begin
      v8 = job.field_low_byte << cfg.shift_amount;
      if (cfg.axis_signed) v8 = v8 + HALF_8;
      if (inv) v8 = ~v8;

      v16 = word;
      if (cfg.axis_bits == BITS_10 || cfg.axis_bits == BITS_12) begin
         v16 = (word >> cfg.axis_bit_position[2:0]) << (WORD_BITS - cfg.axis_bits);
      end
      v16 = v16 << cfg.shift_amount;
      if (cfg.axis_signed) v16 = v16 + CENTRE_16;
      if (inv) v16 = ~v16;

      if (!cfg.axis_present) begin
         norm = CENTRE_16;
      end else begin
         case (cfg.axis_bits)
            BITS_8:                    norm = {v8, 8'h00};
            BITS_10, BITS_12, BITS_16: norm = v16;
            default:                   norm = CENTRE_16;
         endcase
      end
      held_in = job.id_ok ? norm : held_ff;
   end

   assign job_pop = job_valid && (!valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 16'h0000;
         valid_ff <= 1'b0;
      end else begin
         if (job_pop) begin
            held_ff  <= held_in;
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         value_ff   <= held_in;
         below_ff   <= (held_in < LOW_LIMIT);
         above_ff   <= (held_in > HIGH_LIMIT);
         matched_ff <= job.id_ok;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_axis_value     = value_ff;
   assign rsp_below_low      = below_ff;
   assign rsp_above_high     = above_ff;
   assign rsp_report_matched = matched_ff;

endmodule

### hw/rtl/hafn_checker.sv
// port-level checks for the hid axis field normalizer and their bind
module hafn_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [15:0]                       rsp_axis_value,
   input logic                              rsp_below_low,
   input logic                              rsp_above_high,
   input logic                              rsp_report_matched
);
   import hafn_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_axis_value)
         && $stable(rsp_report_matched))
      else $error("result word changed while stalled");

   // flags agree with the value they travel with
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_below_low == (rsp_axis_value < LOW_LIMIT))
         && (rsp_above_high == (rsp_axis_value > HIGH_LIMIT)))
      else $error("threshold flags disagree with axis value");

   // a mismatched report repeats the value of the word before it
   a_mismatch_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 (rsp_valid && !rsp_report_matched)
         |-> rsp_axis_value == $past(rsp_axis_value))
      else $error("mismatched report changed the held value");

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind hid_axis_field_normalizer_top hafn_checker u_hafn_checker (.*);
